// ===== hdl/obba_pkg.sv =====
package obba_pkg;

  localparam int QUAT_FRAC_BITS = 14;

  localparam int COORD_W = 32;
  localparam int EXT_W   = 31;
  localparam int QUAT_W  = 16;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [EXT_W-1:0]          extent_x;
    logic [EXT_W-1:0]          extent_y;
    logic [EXT_W-1:0]          extent_z;
    logic signed [QUAT_W-1:0]  rot_w;
    logic signed [QUAT_W-1:0]  rot_i;
    logic signed [QUAT_W-1:0]  rot_j;
    logic signed [QUAT_W-1:0]  rot_k;
  } box_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lower_x;
    logic signed [COORD_W-1:0] lower_y;
    logic signed [COORD_W-1:0] lower_z;
    logic signed [COORD_W-1:0] upper_x;
    logic signed [COORD_W-1:0] upper_y;
    logic signed [COORD_W-1:0] upper_z;
    logic signed [QUAT_W-1:0]  inv_w;
    logic signed [QUAT_W-1:0]  inv_i;
    logic signed [QUAT_W-1:0]  inv_j;
    logic signed [QUAT_W-1:0]  inv_k;
  } aabb_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] i;
    logic signed [QUAT_W-1:0] j;
    logic signed [QUAT_W-1:0] k;
  } quat_t;

  // advance strobes for the per-axis stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

endpackage

// ===== hdl/obba_axis.sv =====
module obba_axis #(
  parameter int QUAT_FRAC_BITS = obba_pkg::QUAT_FRAC_BITS,
  parameter int ENTRY_W        = 35
) (
  input  logic                                  clk,
  input  obba_pkg::adv_t                        adv,
  input  logic signed [ENTRY_W-1:0]             row [3],
  input  logic [obba_pkg::EXT_W-1:0]            extent [3],
  input  logic signed [obba_pkg::COORD_W-1:0]   center,
  output logic signed [obba_pkg::COORD_W-1:0]   lower,
  output logic signed [obba_pkg::COORD_W-1:0]   upper
);

  localparam int M_W    = ENTRY_W + 1 - QUAT_FRAC_BITS;
  localparam int PROD_W = M_W + obba_pkg::EXT_W;
  localparam int T_W    = PROD_W - QUAT_FRAC_BITS - 1;
  localparam int OFF_W  = T_W + 2;
  localparam int S_W    = OFF_W + 2;
  localparam int CW     = obba_pkg::COORD_W;

  function automatic logic signed [CW-1:0] sat(input logic signed [S_W-1:0] v);
    if (v[S_W-1:CW-1] == '0 || v[S_W-1:CW-1] == '1) begin
      return v[CW-1:0];
    end else if (v[S_W-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // stage 3: rounded entry magnitudes
  logic [M_W-1:0]                  s3_m [3];
  logic [M_W-1:0]                  s3_m_next [3];
  logic [obba_pkg::EXT_W-1:0]      s3_e [3];
  logic signed [CW-1:0]            s3_c;

  // stage 4: half-extent terms
  logic [T_W-1:0]                  s4_t [3];
  logic [T_W-1:0]                  s4_t_next [3];
  logic signed [CW-1:0]            s4_c;

  logic [ENTRY_W-1:0] mag [3];
  logic [ENTRY_W:0]   rnd [3];
  logic [PROD_W-1:0]  prod [3];
  logic [OFF_W-1:0]   off;
  logic signed [S_W-1:0] lo_w;
  logic signed [S_W-1:0] hi_w;

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      mag[b] = row[b][ENTRY_W-1] ? ENTRY_W'(-row[b]) : ENTRY_W'(row[b]);
      rnd[b] = {1'b0, mag[b]} + ((ENTRY_W+1)'(1) << (QUAT_FRAC_BITS - 1));
      s3_m_next[b] = M_W'(rnd[b] >> QUAT_FRAC_BITS);
    end
  end

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      prod[b] = PROD_W'(s3_m[b]) * PROD_W'(s3_e[b]) + (PROD_W'(1) << QUAT_FRAC_BITS);
      s4_t_next[b] = T_W'(prod[b] >> (QUAT_FRAC_BITS + 1));
    end
  end

  // every corner is center +- the sum of the terms
  assign off  = OFF_W'(s4_t[0]) + OFF_W'(s4_t[1]) + OFF_W'(s4_t[2]);
  assign lo_w = S_W'(s4_c) - S_W'($signed({1'b0, off}));
  assign hi_w = S_W'(s4_c) + S_W'($signed({1'b0, off}));

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      s3_m <= s3_m_next;
      s3_e <= extent;
      s3_c <= center;
    end
    if (adv.s4) begin
      s4_t <= s4_t_next;
      s4_c <= s3_c;
    end
    if (adv.s5) begin
      lower <= sat(lo_w);
      upper <= sat(hi_w);
    end
  end

endmodule

// ===== hdl/oriented_box_aabb_core.sv =====
// throughput: one box per cycle while aabb_ready is high; five register stages
// (products, matrix entries, rounded magnitudes, extent products, sum and
// saturation), each stalls on its own
// reset: rst clears the stage valid bits only, the pipeline is empty after reset
module oriented_box_aabb_core #(
  parameter int QUAT_FRAC_BITS = obba_pkg::QUAT_FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           box_valid,
  output logic           box_ready,
  input  obba_pkg::box_t box,
  output logic           aabb_valid,
  input  logic           aabb_ready,
  output obba_pkg::aabb_t aabb
);

  localparam int ENTRY_W = (2 * QUAT_FRAC_BITS + 3 > 35) ? 2 * QUAT_FRAC_BITS + 3 : 35;
  localparam int QW      = obba_pkg::QUAT_W;
  localparam int PW      = 2 * QW;
  localparam int NSTAGE  = 5;

  function automatic logic signed [QW-1:0] neg_sat(input logic signed [QW-1:0] v);
    if (v == {1'b1, {(QW-1){1'b0}}}) begin
      return {1'b0, {(QW-1){1'b1}}};
    end else begin
      return -v;
    end
  endfunction

  logic [NSTAGE-1:0] stage_v;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = ~stage_v[NSTAGE-1] | aabb_ready;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      adv[s] = ~stage_v[s] | adv[s+1];
    end
  end

  assign box_ready  = adv[0];
  assign aabb_valid = stage_v[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      if (adv[0]) begin
        stage_v[0] <= box_valid;
      end
      for (int s = 1; s < NSTAGE; s++) begin
        if (adv[s]) begin
          stage_v[s] <= stage_v[s-1];
        end
      end
    end
  end

  // stage 1: quaternion products
  logic signed [PW-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  obba_pkg::box_t       s1_box;
  obba_pkg::quat_t      s1_inv;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_xx   <= PW'(box.rot_i) * PW'(box.rot_i);
      p_yy   <= PW'(box.rot_j) * PW'(box.rot_j);
      p_zz   <= PW'(box.rot_k) * PW'(box.rot_k);
      p_xy   <= PW'(box.rot_i) * PW'(box.rot_j);
      p_xz   <= PW'(box.rot_i) * PW'(box.rot_k);
      p_yz   <= PW'(box.rot_j) * PW'(box.rot_k);
      p_wx   <= PW'(box.rot_w) * PW'(box.rot_i);
      p_wy   <= PW'(box.rot_w) * PW'(box.rot_j);
      p_wz   <= PW'(box.rot_w) * PW'(box.rot_k);
      s1_box <= box;
      s1_inv <= '{w: box.rot_w, i: neg_sat(box.rot_i), j: neg_sat(box.rot_j),
                  k: neg_sat(box.rot_k)};
    end
  end

  // stage 2: rotation matrix, exact in twice the quaternion fraction
  logic signed [ENTRY_W-1:0] one_c;
  logic signed [ENTRY_W-1:0] r_next [3][3];
  logic signed [ENTRY_W-1:0] s2_r [3][3];
  obba_pkg::box_t            s2_box;
  obba_pkg::quat_t           s2_inv;

  assign one_c = $signed(ENTRY_W'(1) << (2 * QUAT_FRAC_BITS));

  always_comb begin
    r_next[0][0] = one_c - ((ENTRY_W'(p_yy) + ENTRY_W'(p_zz)) <<< 1);
    r_next[0][1] = (ENTRY_W'(p_xy) - ENTRY_W'(p_wz)) <<< 1;
    r_next[0][2] = (ENTRY_W'(p_xz) + ENTRY_W'(p_wy)) <<< 1;
    r_next[1][0] = (ENTRY_W'(p_xy) + ENTRY_W'(p_wz)) <<< 1;
    r_next[1][1] = one_c - ((ENTRY_W'(p_xx) + ENTRY_W'(p_zz)) <<< 1);
    r_next[1][2] = (ENTRY_W'(p_yz) - ENTRY_W'(p_wx)) <<< 1;
    r_next[2][0] = (ENTRY_W'(p_xz) - ENTRY_W'(p_wy)) <<< 1;
    r_next[2][1] = (ENTRY_W'(p_yz) + ENTRY_W'(p_wx)) <<< 1;
    r_next[2][2] = one_c - ((ENTRY_W'(p_xx) + ENTRY_W'(p_yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_r   <= r_next;
      s2_box <= s1_box;
      s2_inv <= s1_inv;
    end
  end

  // stages 3 to 5 run per axis; the inverse rides alongside
  obba_pkg::adv_t  ax_adv;
  obba_pkg::quat_t s3_inv, s4_inv, s5_inv;
  logic [obba_pkg::EXT_W-1:0]          ext [3];
  logic signed [obba_pkg::COORD_W-1:0] ctr [3];
  logic signed [obba_pkg::COORD_W-1:0] lower [3];
  logic signed [obba_pkg::COORD_W-1:0] upper [3];

  assign ax_adv = '{s3: adv[2], s4: adv[3], s5: adv[4]};
  assign ext[0] = s2_box.extent_x;
  assign ext[1] = s2_box.extent_y;
  assign ext[2] = s2_box.extent_z;
  assign ctr[0] = s2_box.center_x;
  assign ctr[1] = s2_box.center_y;
  assign ctr[2] = s2_box.center_z;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_inv <= s2_inv;
    end
    if (adv[3]) begin
      s4_inv <= s3_inv;
    end
    if (adv[4]) begin
      s5_inv <= s4_inv;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    obba_axis #(
      .QUAT_FRAC_BITS(QUAT_FRAC_BITS),
      .ENTRY_W       (ENTRY_W)
    ) u_axis (
      .clk   (clk),
      .adv   (ax_adv),
      .row   (s2_r[a]),
      .extent(ext),
      .center(ctr[a]),
      .lower (lower[a]),
      .upper (upper[a])
    );
  end

  always_comb begin
    aabb.lower_x = lower[0];
    aabb.lower_y = lower[1];
    aabb.lower_z = lower[2];
    aabb.upper_x = upper[0];
    aabb.upper_y = upper[1];
    aabb.upper_z = upper[2];
    aabb.inv_w   = s5_inv.w;
    aabb.inv_i   = s5_inv.i;
    aabb.inv_j   = s5_inv.j;
    aabb.inv_k   = s5_inv.k;
  end

`ifndef SYNTH
  // a full stage that cannot move on keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((stage_v & $past(stage_v & ~adv)) == $past(stage_v & ~adv)))
    else $error("stalled stage lost its word");

  // any bubble in the pipeline lets a new box in
  a_bubble: assert property (@(posedge clk) disable iff (rst)
    !(&stage_v) |-> box_ready)
    else $error("input stalled with a free stage");

  // the box never comes out inverted
  a_order: assert property (@(posedge clk) disable iff (rst)
    aabb_valid |-> (aabb.lower_x <= aabb.upper_x && aabb.lower_y <= aabb.upper_y &&
                    aabb.lower_z <= aabb.upper_z))
    else $error("lower corner above upper corner");
`endif

endmodule
